/* rtl/per_cell_running_mean_variance_macros.svh */
// Assertion helpers for the RTL back end (rmv_back).
`ifndef PER_CELL_RUNNING_MEAN_VARIANCE_MACROS_SVH
`define PER_CELL_RUNNING_MEAN_VARIANCE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check an implication on every clock edge outside reset.
`define RMV_ASSERT_IMPL(lbl, ante, cons, msg) \
	`RMV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/rmv_pkg.sv */
package rmv_pkg;
	localparam int N_COMP_DEF     = 4;
	localparam int CELLS_DEF      = 4096;
	localparam int COUNT_BITS_DEF = 16;

	localparam int IDX_MAX_W   = 20;
	localparam int COUNT_MAX_W = 24;
	localparam int SUM_W       = 32;
	localparam int SQ_W        = 48;
	localparam int DIV_STEPS   = 48;
	localparam int VAR_MAX     = 16384;

	typedef struct packed {
		logic                   is_clear;
		logic                   refused;
		logic [1:0]             comp;
		logic [11:0]            cell_idx;
		logic [IDX_MAX_W-1:0]   idx;
		logic [15:0]            value;
		logic [COUNT_MAX_W-1:0] count;
	} item_t;
endpackage

/* rtl/rmv_if.sv */
interface rmv_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        frame_start;
	logic [31:0] time_step;
	logic [1:0]  component;
	logic [11:0] cell_req;
	logic [15:0] value;
	modport source (output valid, mode, frame_start, time_step, component, cell_req, value,
		input ready);
	modport sink (input valid, mode, frame_start, time_step, component, cell_req, value,
		output ready);
endinterface

interface rmv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_component;
	logic [11:0] out_cell;
	logic [15:0] mean;
	logic [14:0] variance;
	logic [15:0] frames_counted;
	logic        count_full;
	modport source (output valid, out_component, out_cell, mean, variance, frames_counted,
		count_full, input ready);
	modport sink (input valid, out_component, out_cell, mean, variance, frames_counted,
		count_full, output ready);
endinterface

interface rmv_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/rmv_ram.sv */
module rmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/rmv_fifo.sv */
module rmv_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);
	localparam int DEPTH = 4;
	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full      = (cnt_q == 3'(DEPTH));
	assign not_empty = (cnt_q != 3'd0);
	assign rdata     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 2'd1;
			if (pop && not_empty)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && not_empty);
		end
	end
endmodule

/* rtl/rmv_front.sv */
module rmv_front #(
	parameter int N_COMP     = rmv_pkg::N_COMP_DEF,
	parameter int CELLS      = rmv_pkg::CELLS_DEF,
	parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rmv_in_if.sink        samples,
	rmv_cfg_if.sink       cfg,
	input  logic          init_busy,
	input  logic          q_full,
	output logic          q_push,
	output rmv_pkg::item_t q_item
);
	import rmv_pkg::*;

	logic [31:0]           eq_q;
	logic [COUNT_BITS-1:0] fc_q, fc_next;
	logic                  refused_q, refused_next;
	logic                  accept, active, in_range;
	logic [31:0]           idx_full;

	assign cfg.ready     = 1'b1;
	assign samples.ready = !q_full && !init_busy;
	assign accept        = samples.valid && samples.ready;
	assign active        = samples.time_step >= eq_q;
	assign in_range      = (32'(samples.component) < 32'(N_COMP))
		&& (32'(samples.cell_req) < 32'(CELLS));
	assign idx_full      = 32'(samples.component) * 32'(CELLS) + 32'(samples.cell_req);

	always_comb begin
		fc_next      = fc_q;
		refused_next = refused_q;
		if (samples.frame_start) begin
			if (fc_q != '1) begin
				fc_next      = fc_q + 1'b1;
				refused_next = 1'b0;
			end else begin
				refused_next = 1'b1;
			end
		end
	end

	assign q_push = accept && (samples.mode || (active && in_range));

	always_comb begin
		q_item          = '0;
		q_item.is_clear = samples.mode;
		q_item.refused  = refused_next;
		q_item.comp     = samples.component;
		q_item.cell_idx = samples.cell_req;
		q_item.idx      = idx_full[IDX_MAX_W-1:0];
		q_item.value    = samples.value;
		q_item.count    = COUNT_MAX_W'(fc_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_q      <= '0;
			fc_q      <= '0;
			refused_q <= 1'b0;
		end else begin
			if (cfg.valid)
				eq_q <= cfg.data;
			if (accept) begin
				if (samples.mode) begin
					fc_q      <= '0;
					refused_q <= 1'b0;
				end else if (active) begin
					fc_q      <= fc_next;
					refused_q <= refused_next;
				end
			end
		end
	end
endmodule

/* rtl/rmv_back.sv */
module rmv_back #(
	parameter int N_COMP     = rmv_pkg::N_COMP_DEF,
	parameter int CELLS      = rmv_pkg::CELLS_DEF,
	parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rmv_pkg::item_t q_item,
	output logic           q_pop,
	output logic           init_busy,
	rmv_out_if.source      results
);
	import rmv_pkg::*;
	`include "per_cell_running_mean_variance_macros.svh"

	localparam int ELEMS = N_COMP * CELLS;
	localparam int AW    = ELEMS > 1 ? $clog2(ELEMS) : 1;
	localparam int RW    = SUM_W + SQ_W;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_DIV  = 6'b001000,
		S_VAR  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                state_q;
	logic                  init_q;
	logic [AW-1:0]         clr_q;
	item_t                 item_q;
	logic [5:0]            step_q;
	logic [SQ_W-1:0]       sd_q, qd_q;
	logic [COUNT_BITS:0]   rs_q, rq_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [15:0]           mean_q;
	logic [31:0]           m2_q;

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [RW-1:0]         wdata, rdata;
	logic [SUM_W-1:0]      new_sum;
	logic [SQ_W-1:0]       new_sq;
	logic [COUNT_BITS:0]   rs_sh, rq_sh, nd;
	logic                  out_free;
	logic [15:0]           m_sat;
	logic [SQ_W-1:0]       var_diff;
	logic [31:0]           var_raw;
	logic [14:0]           var_sat;

	rmv_ram #(.WIDTH(RW), .DEPTH(ELEMS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign init_busy = init_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign raddr     = q_item.idx[AW-1:0];

	assign new_sum = rdata[RW-1:SQ_W] + SUM_W'(item_q.value);
	assign new_sq  = rdata[SQ_W-1:0] + SQ_W'(32'(item_q.value) * 32'(item_q.value));

	always_comb begin
		we    = 1'b0;
		waddr = item_q.idx[AW-1:0];
		wdata = {new_sum, new_sq};
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_RD && !item_q.refused) begin
			we = 1'b1;
		end
	end

	// one restoring division step on both dividends
	assign nd    = {1'b0, n_q};
	assign rs_sh = {rs_q[COUNT_BITS-1:0], sd_q[SQ_W-1]};
	assign rq_sh = {rq_q[COUNT_BITS-1:0], qd_q[SQ_W-1]};

	assign out_free = !results.valid || results.ready;
	assign m_sat    = (|sd_q[SQ_W-1:16]) ? 16'hFFFF : sd_q[15:0];
	assign var_diff = qd_q - SQ_W'(m2_q);
	assign var_raw  = (qd_q > SQ_W'(m2_q)) ? var_diff[SQ_W-1:16] : 32'd0;
	assign var_sat  = (var_raw > 32'(VAR_MAX)) ? 15'(VAR_MAX) : var_raw[14:0];

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid)
					item_q <= q_item;
			end
			S_RD: begin
				rs_q  <= '0;
				rq_q  <= '0;
				n_q   <= item_q.count[COUNT_BITS-1:0];
				step_q <= '0;
				if (item_q.count == '0) begin
					sd_q <= '0;
					qd_q <= '0;
				end else begin
					sd_q <= item_q.refused ? SQ_W'(rdata[RW-1:SQ_W]) : SQ_W'(new_sum);
					qd_q <= item_q.refused ? rdata[SQ_W-1:0] : new_sq;
				end
			end
			S_DIV: begin
				step_q <= step_q + 6'd1;
				rs_q   <= (rs_sh >= nd) ? rs_sh - nd : rs_sh;
				rq_q   <= (rq_sh >= nd) ? rq_sh - nd : rq_sh;
				sd_q   <= {sd_q[SQ_W-2:0], rs_sh >= nd};
				qd_q   <= {qd_q[SQ_W-2:0], rq_sh >= nd};
			end
			S_VAR: begin
				mean_q <= m_sat;
				m2_q   <= 32'(m_sat) * 32'(m_sat);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			init_q        <= 1'b1;
			clr_q         <= '0;
			results.valid <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				results.valid <= 1'b1;
			else if (results.ready)
				results.valid <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (clr_q == AW'(ELEMS - 1)) begin
						clr_q   <= '0;
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (q_valid)
						state_q <= q_item.is_clear ? S_CLR : S_RD;
				end
				S_RD: state_q <= (item_q.count == '0) ? S_VAR : S_DIV;
				S_DIV: begin
					if (step_q == 6'(DIV_STEPS - 1))
						state_q <= S_VAR;
				end
				S_VAR: state_q <= S_FIN;
				S_FIN: begin
					// hold until the output register is free
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			results.out_component  <= item_q.comp;
			results.out_cell       <= item_q.cell_idx;
			results.mean           <= mean_q;
			results.variance       <= var_sat;
			results.frames_counted <= item_q.count[15:0];
			results.count_full     <= item_q.refused;
		end
	end

	`RMV_ASSERT_IMPL(a_no_pop_clr, state_q == S_CLR, !q_pop, "queue popped during clear sweep")
	`RMV_ASSERT_IMPL(a_we_state, we, state_q == S_CLR || state_q == S_RD, "store written out of turn")
	`RMV_ASSERT_IMPL(a_out_from_fin, $rose(results.valid), $past(state_q) == S_FIN, "result without finish")
	`RMV_ASSERT_IMPL(a_init_clr, init_q, state_q == S_CLR, "init flag outside clear sweep")
endmodule

/* rtl/per_cell_running_mean_variance.sv */
// Per-element running mean and variance of field samples.
// Channels: samples (sink) take one tagged sample or a clear command per
// transfer; results (source) return component, cell, mean, variance, frame
// count and a saturation flag; cfg (sink) writes the equilibration step; the user
// must write it only while the block is idle, as the block does not enforce this.
// Samples are classified by the front end and queued (four entries) for the
// back end, which reads and updates the element store, then runs a bit-serial
// restoring divider on sum and sum of squares by the frame count.
// The back end handles one item at a time and takes no new item until its
// result is registered; samples without a result are not queued.
// Reset and clear mode sweep all N_COMP*CELLS entries of the element store
// (16384 by default) one entry a cycle; after reset no sample is taken
// until that sweep ends. A stalled result holds in the output register and
// the back end waits, while the queue keeps taking samples until full.
module per_cell_running_mean_variance #(
	parameter int N_COMP     = rmv_pkg::N_COMP_DEF,
	parameter int CELLS      = rmv_pkg::CELLS_DEF,
	parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rmv_in_if.sink    samples,
	rmv_out_if.source results,
	rmv_cfg_if.sink   cfg
);
	import rmv_pkg::*;

	item_t push_item, pop_item;
	logic  push, full, pop, not_empty, init_busy;

	rmv_front #(.N_COMP(N_COMP), .CELLS(CELLS), .COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .samples(samples), .cfg(cfg), .init_busy(init_busy),
		.q_full(full), .q_push(push), .q_item(push_item)
	);

	rmv_fifo #(.WIDTH($bits(item_t))) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_item), .full(full),
		.pop(pop), .rdata(pop_item), .not_empty(not_empty)
	);

	rmv_back #(.N_COMP(N_COMP), .CELLS(CELLS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(not_empty), .q_item(pop_item), .q_pop(pop),
		.init_busy(init_busy), .results(results)
	);
endmodule
